// ----- sv/grid_astar_path_search_unit_assert.svh -----
// Assertion macros for the grid path search unit.
// Used by the top level; needs nothing else.
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define GAPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante holds -> cons holds in the next cycle
`define GAPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/gaps_pkg.sv -----
// Types and constants of the grid path search unit.
// Used by gaps_step_unit and grid_astar_path_search_unit.
`default_nettype none

package gaps_pkg;

   localparam int GRID_DIM   = 16;
   localparam int NCELLS     = GRID_DIM * GRID_DIM;
   localparam int COORD_W    = 4;
   localparam int DIM_W      = 5;
   localparam int CELL_W     = 8;
   localparam int COST_W     = 8;
   localparam int HCOST_W    = 5;
   localparam int F_W        = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   typedef logic [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      ST_FOUND    = 2'd0,
      ST_NO_PATH  = 2'd1,
      ST_TOO_LONG = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 3'd0,
      CSR_GRID_HEIGHT = 3'd1,
      CSR_START_X     = 3'd2,
      CSR_START_Y     = 3'd3,
      CSR_GOAL_X      = 3'd4,
      CSR_GOAL_Y      = 3'd5
   } csr_index_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      dir_type   dir;
      logic      step;
   } step_in_type;

   typedef struct packed {
      coord_type          x;
      coord_type          y;
      logic               in_grid;
      logic [CELL_W-1:0]  lin;
      logic [HCOST_W-1:0] hcost;
   } step_out_type;

   typedef struct packed {
      coord_type      x;
      coord_type      y;
      logic [F_W-1:0] f;
   } open_entry_type;

endpackage

`default_nettype wire

// ----- sv/gaps_step_unit.sv -----
// Shared cell unit: one grid step, bounds check, linear cell index, Manhattan cost.
// Depends on gaps_pkg.
`default_nettype none

module gaps_step_unit import gaps_pkg::*; (
   input  step_in_type        step_i,
   input  logic [DIM_W-1:0]   width_i,
   input  logic [DIM_W-1:0]   height_i,
   input  coord_type          goal_x_i,
   input  coord_type          goal_y_i,
   output step_out_type       step_o
);

   logic signed [DIM_W:0]        dx, dy, px, py;
   coord_type                    nx, ny, ax, ay;
   logic [COORD_W+DIM_W-1:0]     prod, lin_full;

   always_comb begin
      dx = '0;
      dy = '0;
      if (step_i.step) begin
         case (step_i.dir)
            DIR_UP:    dy = -6'sd1;
            DIR_RIGHT: dx = 6'sd1;
            DIR_DOWN:  dy = 6'sd1;
            DIR_LEFT:  dx = -6'sd1;
            default:   dx = '0;
         endcase
      end
      px = signed'({2'b00, step_i.x}) + dx;
      py = signed'({2'b00, step_i.y}) + dy;
      nx = px[COORD_W-1:0];
      ny = py[COORD_W-1:0];
      ax = (nx > goal_x_i) ? nx - goal_x_i : goal_x_i - nx;
      ay = (ny > goal_y_i) ? ny - goal_y_i : goal_y_i - ny;
      prod = {{DIM_W{1'b0}}, ny} * {{COORD_W{1'b0}}, width_i};
      lin_full = prod + {{DIM_W{1'b0}}, nx};
      step_o.x = nx;
      step_o.y = ny;
      step_o.in_grid = !px[DIM_W] && !py[DIM_W] && (px[DIM_W-1:0] < width_i)
                       && (py[DIM_W-1:0] < height_i);
      step_o.lin = lin_full[CELL_W-1:0];
      step_o.hcost = {1'b0, ax} + {1'b0, ay};
   end

endmodule

`default_nettype wire

// ----- sv/grid_astar_path_search_unit.sv -----
// Grid A* path search: loads a wall map one cell per cycle, one cell per transaction.
// After the last cell the search runs with req_tready low; each pop scans the open list
// for the lowest f and compacts it by moving each later entry down, then checks the four
// neighbors; trace back and emit then walk the path cells. All through one step unit and
// memories with one write port each. Synchronous reset clears control and CSR state only.
`default_nettype none

`include "grid_astar_path_search_unit_assert.svh"

module grid_astar_path_search_unit import gaps_pkg::*; #(
   parameter int MAX_PATH   = 64,
   parameter int OPEN_DEPTH = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] wall, [7:1] zero
   input  logic                  req_tlast,   // last_cell
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [3:0] cell_col, [7:4] cell_row
   output logic [2:0]            rsp_tuser,   // [0] has_cell, [2:1] status
   output logic                  rsp_tlast,   // last_result
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int OPEN_IDX_W = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
   localparam int OPEN_CNT_W = $clog2(OPEN_DEPTH + 1);
   localparam int PATH_IDX_W = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;
   localparam int PATH_CNT_W = $clog2(MAX_PATH + 1);

   typedef enum logic [3:0] {
      S_LOAD, S_INIT, S_POP, S_SCAN_RD, S_SCAN_CMP, S_REMOVE, S_MOVE_WR, S_CUR,
      S_LOAD_G, S_NB_RD, S_NB_CHK, S_TRACE, S_TRACE_STEP, S_EMIT_RD, S_EMIT, S_STAT
   } state_type;

   state_type               state_ff;
   logic [CELL_W-1:0]       li_ff;
   logic [DIM_W-1:0]        gw_ff, gh_ff;
   coord_type               sx_ff, sy_ff, gx_ff, gy_ff;
   logic [OPEN_CNT_W-1:0]   count_ff;
   logic [OPEN_IDX_W-1:0]   k_ff, best_idx_ff;
   logic [F_W-1:0]          best_f_ff;
   coord_type               cx_ff, cy_ff;
   logic [COST_W-1:0]       g_ff;
   dir_type                 dir_ff;
   logic [PATH_CNT_W-1:0]   len_ff;
   logic [PATH_IDX_W-1:0]   pk_ff;
   status_type              stat_ff;
   logic [NCELLS-1:0]       known_ff;
   logic                    rsp_valid_ff;
   coord_type               rsp_col_ff, rsp_row_ff;
   logic                    rsp_has_ff, rsp_last_ff;
   status_type              rsp_stat_ff;

   logic                    wall_mem [NCELLS];
   logic [COST_W-1:0]       cost_mem [NCELLS];
   logic [1:0]              from_mem [NCELLS];
   open_entry_type          open_mem [OPEN_DEPTH];
   logic [2*COORD_W-1:0]    path_mem [MAX_PATH];

   logic                    wall_q_ff;
   logic [COST_W-1:0]       cost_q_ff;
   logic [1:0]              from_q_ff;
   open_entry_type          open_q_ff;
   logic [2*COORD_W-1:0]    path_q_ff;

   logic [DIM_W-1:0]        wc, hc;
   step_in_type             u_in;
   step_out_type            u_out;
   logic                    req_acc, out_free, start_ok, at_goal, at_start, take;
   logic                    improve, full;
   logic [COST_W-1:0]       t_cost;
   logic [OPEN_CNT_W-1:0]   k_ext;
   logic                    cost_we, from_we, open_we, path_we;
   logic [OPEN_IDX_W-1:0]   open_waddr, open_raddr;
   open_entry_type          open_wdata;

   always_comb begin
      wc = (gw_ff == '0) ? DIM_W'(1) : ((gw_ff > DIM_W'(GRID_DIM)) ? DIM_W'(GRID_DIM) : gw_ff);
      hc = (gh_ff == '0) ? DIM_W'(1) : ((gh_ff > DIM_W'(GRID_DIM)) ? DIM_W'(GRID_DIM) : gh_ff);
   end

   always_comb begin
      u_in = '{x: cx_ff, y: cy_ff, dir: dir_ff, step: 1'b0};
      case (state_ff)
         S_INIT: begin
            u_in.x = sx_ff;
            u_in.y = sy_ff;
         end
         S_NB_RD, S_NB_CHK: u_in.step = 1'b1;
         S_TRACE_STEP: begin
            u_in.dir = dir_type'(from_q_ff ^ 2'b10);
            u_in.step = 1'b1;
         end
         default: u_in.step = 1'b0;
      endcase
   end

   gaps_step_unit u_step (
      .step_i   (u_in),
      .width_i  (wc),
      .height_i (hc),
      .goal_x_i (gx_ff),
      .goal_y_i (gy_ff),
      .step_o   (u_out)
   );

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign start_ok   = ({1'b0, sx_ff} < wc) && ({1'b0, sy_ff} < hc);
   assign at_goal    = (cx_ff == gx_ff) && (cy_ff == gy_ff);
   assign at_start   = (cx_ff == sx_ff) && (cy_ff == sy_ff);
   assign take       = open_q_ff.f < best_f_ff;
   assign t_cost     = g_ff + COST_W'(1);
   assign improve    = !wall_q_ff && (!known_ff[u_out.lin] || (t_cost < cost_q_ff));
   assign full       = (count_ff == OPEN_CNT_W'(OPEN_DEPTH));
   assign k_ext      = OPEN_CNT_W'(k_ff) + OPEN_CNT_W'(1);

   assign cost_we = ((state_ff == S_INIT) && start_ok) || ((state_ff == S_NB_CHK) && improve);
   assign from_we = (state_ff == S_NB_CHK) && improve;
   assign path_we = (state_ff == S_TRACE) && !at_start && (len_ff < PATH_CNT_W'(MAX_PATH));

   always_comb begin
      open_we    = 1'b0;
      open_waddr = k_ff;
      open_wdata = open_q_ff;
      open_raddr = k_ff;
      case (state_ff)
         S_INIT: begin
            open_we    = start_ok;
            open_waddr = '0;
            open_wdata = '{x: sx_ff, y: sy_ff, f: F_W'(u_out.hcost)};
         end
         S_MOVE_WR: open_we = 1'b1;
         S_REMOVE:  open_raddr = k_ext[OPEN_IDX_W-1:0];
         S_NB_CHK: begin
            open_we    = improve && !full;
            open_waddr = count_ff[OPEN_IDX_W-1:0];
            open_wdata = '{x: u_out.x, y: u_out.y,
                           f: F_W'(t_cost) + F_W'(u_out.hcost)};
         end
         default: open_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         wall_mem[li_ff] <= req_tdata[0];
      end
      wall_q_ff <= wall_mem[u_out.lin];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[u_out.lin] <= (state_ff == S_INIT) ? '0 : t_cost;
      end
      cost_q_ff <= cost_mem[u_out.lin];
   end

   always_ff @(posedge clock) begin
      if (from_we) begin
         from_mem[u_out.lin] <= dir_ff;
      end
      from_q_ff <= from_mem[u_out.lin];
   end

   always_ff @(posedge clock) begin
      if (open_we) begin
         open_mem[open_waddr] <= open_wdata;
      end
      open_q_ff <= open_mem[open_raddr];
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[len_ff[PATH_IDX_W-1:0]] <= {cy_ff, cx_ff};
      end
      path_q_ff <= path_mem[pk_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         li_ff        <= '0;
         gw_ff        <= DIM_W'(16);
         gh_ff        <= DIM_W'(16);
         sx_ff        <= '0;
         sy_ff        <= '0;
         gx_ff        <= COORD_W'(15);
         gy_ff        <= COORD_W'(15);
         count_ff     <= '0;
         known_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_WIDTH:  gw_ff <= csr_data;
               CSR_GRID_HEIGHT: gh_ff <= csr_data;
               CSR_START_X:     sx_ff <= csr_data[COORD_W-1:0];
               CSR_START_Y:     sy_ff <= csr_data[COORD_W-1:0];
               CSR_GOAL_X:      gx_ff <= csr_data[COORD_W-1:0];
               CSR_GOAL_Y:      gy_ff <= csr_data[COORD_W-1:0];
               default:         gw_ff <= gw_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_EMIT) && (state_ff != S_STAT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_acc) begin
                  if (req_tlast) begin
                     li_ff    <= '0;
                     state_ff <= S_INIT;
                  end else begin
                     li_ff <= li_ff + CELL_W'(1);
                  end
               end
            end
            S_INIT: begin
               if (!start_ok) begin
                  stat_ff  <= ST_NO_PATH;
                  state_ff <= S_STAT;
               end else begin
                  known_ff <= NCELLS'(1) << u_out.lin;
                  count_ff <= OPEN_CNT_W'(1);
                  state_ff <= S_POP;
               end
            end
            S_POP: begin
               if (count_ff == '0) begin
                  stat_ff  <= ST_NO_PATH;
                  state_ff <= S_STAT;
               end else begin
                  k_ff        <= '0;
                  best_idx_ff <= '0;
                  best_f_ff   <= '1;
                  state_ff    <= S_SCAN_RD;
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CMP;
            S_SCAN_CMP: begin
               if (take) begin
                  best_f_ff   <= open_q_ff.f;
                  best_idx_ff <= k_ff;
                  cx_ff       <= open_q_ff.x;
                  cy_ff       <= open_q_ff.y;
               end
               if (k_ext == count_ff) begin
                  k_ff     <= take ? k_ff : best_idx_ff;
                  state_ff <= S_REMOVE;
               end else begin
                  k_ff     <= k_ext[OPEN_IDX_W-1:0];
                  state_ff <= S_SCAN_RD;
               end
            end
            S_REMOVE: begin
               if (k_ext < count_ff) begin
                  state_ff <= S_MOVE_WR;
               end else begin
                  count_ff <= count_ff - OPEN_CNT_W'(1);
                  state_ff <= S_CUR;
               end
            end
            S_MOVE_WR: begin
               k_ff     <= k_ext[OPEN_IDX_W-1:0];
               state_ff <= S_REMOVE;
            end
            S_CUR: begin
               if (at_goal) begin
                  len_ff   <= '0;
                  state_ff <= S_TRACE;
               end else begin
                  state_ff <= S_LOAD_G;
               end
            end
            S_LOAD_G: begin
               g_ff     <= cost_q_ff;
               dir_ff   <= DIR_UP;
               state_ff <= S_NB_RD;
            end
            S_NB_RD: begin
               if (u_out.in_grid) begin
                  state_ff <= S_NB_CHK;
               end else if (dir_ff == DIR_LEFT) begin
                  state_ff <= S_POP;
               end else begin
                  dir_ff <= dir_type'(dir_ff + 2'd1);
               end
            end
            S_NB_CHK: begin
               if (improve && full) begin
                  stat_ff  <= ST_OVERFLOW;
                  state_ff <= S_STAT;
               end else begin
                  if (improve) begin
                     known_ff[u_out.lin] <= 1'b1;
                     count_ff            <= count_ff + OPEN_CNT_W'(1);
                  end
                  if (dir_ff == DIR_LEFT) begin
                     state_ff <= S_POP;
                  end else begin
                     dir_ff   <= dir_type'(dir_ff + 2'd1);
                     state_ff <= S_NB_RD;
                  end
               end
            end
            S_TRACE: begin
               if (at_start) begin
                  if (len_ff == '0) begin
                     stat_ff  <= ST_FOUND;
                     state_ff <= S_STAT;
                  end else begin
                     pk_ff    <= PATH_IDX_W'(len_ff - PATH_CNT_W'(1));
                     state_ff <= S_EMIT_RD;
                  end
               end else if (len_ff >= PATH_CNT_W'(MAX_PATH)) begin
                  stat_ff  <= ST_TOO_LONG;
                  state_ff <= S_STAT;
               end else begin
                  len_ff   <= len_ff + PATH_CNT_W'(1);
                  state_ff <= S_TRACE_STEP;
               end
            end
            S_TRACE_STEP: begin
               cx_ff    <= u_out.x;
               cy_ff    <= u_out.y;
               state_ff <= S_TRACE;
            end
            S_EMIT_RD: state_ff <= S_EMIT;
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_col_ff   <= path_q_ff[COORD_W-1:0];
                  rsp_row_ff   <= path_q_ff[2*COORD_W-1:COORD_W];
                  rsp_has_ff   <= 1'b1;
                  rsp_stat_ff  <= ST_FOUND;
                  rsp_last_ff  <= (pk_ff == '0);
                  if (pk_ff == '0) begin
                     state_ff <= S_LOAD;
                  end else begin
                     pk_ff    <= pk_ff - PATH_IDX_W'(1);
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            S_STAT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_col_ff   <= '0;
                  rsp_row_ff   <= '0;
                  rsp_has_ff   <= 1'b0;
                  rsp_stat_ff  <= stat_ff;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = {rsp_stat_ff, rsp_has_ff};
   assign rsp_tlast  = rsp_last_ff;

   `GAPS_ASSERT_NOW(a_open_bound, clock, reset, 1'b1, count_ff <= OPEN_CNT_W'(OPEN_DEPTH), "open list count beyond depth")
   `GAPS_ASSERT_NOW(a_path_bound, clock, reset, 1'b1, len_ff <= PATH_CNT_W'(MAX_PATH), "path length beyond buffer")
   `GAPS_ASSERT_NEXT(a_search_start, clock, reset, req_acc && req_tlast, (state_ff == S_INIT) && (li_ff == '0), "last cell did not start search")
   `GAPS_ASSERT_NOW(a_nb_in_grid, clock, reset, state_ff == S_NB_CHK, u_out.in_grid, "neighbor check outside grid")

endmodule

`default_nettype wire

// ----- test/tb_grid_astar_path_search_unit.sv -----
// Self-checking testbench for grid_astar_path_search_unit: loads wall maps, runs searches
// and compares every path or status transaction with a built-in A* predictor or a typed status.
// Depends on gaps_pkg and the unit's RTL only.
`default_nettype none

module tb_grid_astar_path_search_unit;
   import gaps_pkg::*;

   typedef struct {
      logic [3:0] col;
      logic [3:0] row;
      logic       has;
      status_type status;
      logic       last;
   } path_result_type;

   typedef struct {
      int lin;
      int f;
   } open_item_type;

   typedef enum int {PAT_OPEN, PAT_GOAL_WALL, PAT_START_WALL, PAT_SPLIT, PAT_SERPENT} pattern_type;

   typedef struct {
      int          w, h, sx, sy, gx, gy;
      int          nload;      // 0: width * height cells
      pattern_type pat;
      bit          typed;      // expected status typed in below
      status_type  st;
      logic        has;
      bit          hold;       // long receiver hold-off during this run
   } run_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid, req_tready, req_tlast;
   logic [7:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tlast;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   path_result_type path_exp_q[$];
   int fail_count = 0;
   int cfg_w, cfg_h, cfg_sx, cfg_sy, cfg_gx, cfg_gy;
   bit wall_mem[NCELLS];
   bit cell_written[NCELLS];
   int best_g[NCELLS];
   bit g_known[NCELLS];
   int came_dir[NCELLS];
   bit run_walls[NCELLS];
   int load_ptr;
   int burst_left = 0;
   int item_count = 0;
   bit hold_ask = 0;

   grid_astar_path_search_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb_grid_astar_path_search_unit failed");
      $finish;
   end

   function automatic int clamp_dim(int v);
      if (v < 1) return 1;
      if (v > GRID_DIM) return GRID_DIM;
      return v;
   endfunction

   function automatic int step_x(int d);
      case (dir_type'(d))
         DIR_RIGHT: return 1;
         DIR_LEFT:  return -1;
         default:   return 0;
      endcase
   endfunction

   function automatic int step_y(int d);
      case (dir_type'(d))
         DIR_UP:   return -1;
         DIR_DOWN: return 1;
         default:  return 0;
      endcase
   endfunction

   function automatic int dist_to_goal(int x, int y);
      return (x > cfg_gx ? x - cfg_gx : cfg_gx - x) + (y > cfg_gy ? y - cfg_gy : cfg_gy - y);
   endfunction

   function automatic void push_result(int col, int row, logic has, status_type st,
                                       logic last);
      path_result_type r;
      r.col = col[3:0];
      r.row = row[3:0];
      r.has = has;
      r.status = st;
      r.last = last;
      path_exp_q = {path_exp_q, r};
   endfunction

   function automatic void predict_search();
      int w, h, s, cur, cx, cy, best, nx, ny, nb, t, len, steps, d, c;
      int trail[$];
      open_item_type open_q[$];
      open_item_type e;
      w = clamp_dim(cfg_w);
      h = clamp_dim(cfg_h);
      if (cfg_sx >= w || cfg_sy >= h) begin
         push_result(0, 0, 1'b0, ST_NO_PATH, 1'b1);
         return;
      end
      foreach (g_known[i]) g_known[i] = 0;
      s = cfg_sy * w + cfg_sx;
      best_g[s] = 0;
      g_known[s] = 1;
      e.lin = s;
      e.f = dist_to_goal(cfg_sx, cfg_sy);
      open_q = {open_q, e};
      while (open_q.size() > 0) begin
         best = 0;
         for (int k = 1; k < open_q.size(); k++)
            if (open_q[k].f < open_q[best].f) best = k;
         cur = open_q[best].lin;
         open_q.delete(best);
         cx = cur % w;
         cy = cur / w;
         if (cx == cfg_gx && cy == cfg_gy) begin
            len = 0;
            steps = 0;
            while (cur != s && steps < NCELLS) begin
               if (len >= 64) begin
                  push_result(0, 0, 1'b0, ST_TOO_LONG, 1'b1);
                  return;
               end
               trail = {trail, cur};
               len++;
               d = came_dir[cur];
               cx = cx - step_x(d);
               cy = cy - step_y(d);
               cur = cy * w + cx;
               steps++;
            end
            if (len == 0) push_result(0, 0, 1'b0, ST_FOUND, 1'b1);
            for (int n = 0; n < len; n++) begin
               c = trail[len - 1 - n];
               push_result(c % w, c / w, 1'b1, ST_FOUND, n == len - 1);
            end
            return;
         end
         for (int i = 0; i < 4; i++) begin
            nx = cx + step_x(i);
            ny = cy + step_y(i);
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
            nb = ny * w + nx;
            if (wall_mem[nb]) continue;
            t = best_g[cur] + 1;
            if (!g_known[nb] || t < best_g[nb]) begin
               came_dir[nb] = i;
               best_g[nb] = t;
               g_known[nb] = 1;
               if (open_q.size() >= 512) begin
                  push_result(0, 0, 1'b0, ST_OVERFLOW, 1'b1);
                  return;
               end
               e.lin = nb;
               e.f = t + dist_to_goal(nx, ny);
               open_q = {open_q, e};
            end
         end
      end
      push_result(0, 0, 1'b0, ST_NO_PATH, 1'b1);
   endfunction

   // result checker
   always @(posedge clock) begin
      path_result_type x;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (path_exp_q.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            x = path_exp_q.pop_front();
            if (rsp_tdata[3:0] !== x.col) begin
               $error("cell_col expected %0d actual %0d", x.col, rsp_tdata[3:0]);
               fail_count++;
            end
            if (rsp_tdata[7:4] !== x.row) begin
               $error("cell_row expected %0d actual %0d", x.row, rsp_tdata[7:4]);
               fail_count++;
            end
            if (rsp_tuser[0] !== x.has) begin
               $error("has_cell expected %0d actual %0d", x.has, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[2:1] !== x.status) begin
               $error("status expected %0d actual %0d", x.status, rsp_tuser[2:1]);
               fail_count++;
            end
            if (rsp_tlast !== x.last) begin
               $error("last_result expected %0d actual %0d", x.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // receiver: changing stall pattern plus one long hold-off on request
   initial begin
      int mode, left, hold_cnt;
      rsp_tready <= 1'b0;
      mode = 0;
      left = 0;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 0;
            hold_cnt = 600;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(10, 80);
         end
         left--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 0);
               2: rsp_tready <= ($urandom_range(0, 4) != 0);
               default: rsp_tready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   task automatic csr_put(csr_index_type idx, int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_grid(int w, int h, int sx, int sy, int gx, int gy);
      csr_put(CSR_GRID_WIDTH, w);
      csr_put(CSR_GRID_HEIGHT, h);
      csr_put(CSR_START_X, sx);
      csr_put(CSR_START_Y, sy);
      csr_put(CSR_GOAL_X, gx);
      csr_put(CSR_GOAL_Y, gy);
      csr_valid <= 1'b0;
      cfg_w = w;
      cfg_h = h;
      cfg_sx = sx;
      cfg_sy = sy;
      cfg_gx = gx;
      cfg_gy = gy;
   endtask

   task automatic send_cell(bit wall, bit last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, wall};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // loads n cells from run_walls, predicts or queues the typed result, then waits for the
   // block to drain; with hold the same load goes again while the receiver holds off
   task automatic load_and_search(int n, bit typed, status_type st, logic has, bit hold);
      int idx;
      for (int rep = 0; rep < (hold ? 2 : 1); rep++) begin
         for (int i = 0; i < n; i++) begin
            idx = load_ptr;
            wall_mem[idx] = run_walls[i];
            cell_written[idx] = 1;
            if (i == n - 1) begin
               load_ptr = 0;
               if (typed) push_result(0, 0, has, st, 1'b1);
               else predict_search();
            end else begin
               load_ptr = load_ptr + 1;
            end
            send_cell(run_walls[i], i == n - 1);
         end
         item_count += n;
         if (hold && rep == 0) hold_ask = 1;
      end
      req_tvalid <= 1'b0;
      while (path_exp_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic void fill_pattern(pattern_type p, int w, int h);
      for (int i = 0; i < NCELLS; i++) run_walls[i] = 0;
      case (p)
         PAT_GOAL_WALL:  run_walls[cfg_gy * w + cfg_gx] = 1;
         PAT_START_WALL: run_walls[cfg_sy * w + cfg_sx] = 1;
         PAT_SPLIT:      for (int y = 0; y < h; y++) run_walls[y * w + 1] = 1;
         PAT_SERPENT: begin
            for (int y = 1; y < h; y += 2)
               for (int x = 0; x < w; x++)
                  run_walls[y * w + x] = !(x == ((y % 4 == 1) ? w - 1 : 0));
         end
         default: ;
      endcase
   endfunction

   run_row_type plan[12] = '{
      '{16, 1, 0, 0, 15, 0, 0, PAT_OPEN, 0, ST_FOUND, 1'b0, 1},
      '{1, 6, 0, 0, 0, 5, 0, PAT_OPEN, 0, ST_FOUND, 1'b0, 0},
      '{3, 3, 2, 2, 2, 2, 0, PAT_OPEN, 1, ST_FOUND, 1'b0, 0},
      '{3, 3, 15, 0, 1, 1, 0, PAT_OPEN, 1, ST_NO_PATH, 1'b0, 0},
      '{3, 3, 0, 0, 15, 15, 0, PAT_OPEN, 1, ST_NO_PATH, 1'b0, 0},
      '{3, 3, 0, 0, 2, 2, 0, PAT_GOAL_WALL, 1, ST_NO_PATH, 1'b0, 0},
      '{3, 3, 0, 0, 2, 1, 0, PAT_START_WALL, 0, ST_FOUND, 1'b0, 0},
      '{3, 3, 0, 0, 2, 0, 0, PAT_SPLIT, 1, ST_NO_PATH, 1'b0, 0},
      '{0, 31, 0, 0, 0, 15, 0, PAT_OPEN, 0, ST_FOUND, 1'b0, 0},
      '{16, 7, 0, 0, 0, 6, 0, PAT_SERPENT, 1, ST_TOO_LONG, 1'b0, 0},
      '{4, 4, 0, 0, 3, 3, 5, PAT_OPEN, 0, ST_FOUND, 1'b0, 0},
      '{3, 3, 0, 2, 2, 0, 12, PAT_OPEN, 0, ST_FOUND, 1'b0, 0}
   };

   initial begin
      int w, h, n, sx, sy, gx, gy, cw, ch;
      bit all_known;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'd0;
      req_tlast <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_GRID_WIDTH;
      csr_data <= '0;
      load_ptr = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      foreach (plan[r]) begin
         set_grid(plan[r].w, plan[r].h, plan[r].sx, plan[r].sy, plan[r].gx, plan[r].gy);
         w = clamp_dim(plan[r].w);
         h = clamp_dim(plan[r].h);
         fill_pattern(plan[r].pat, w, h);
         n = plan[r].nload == 0 ? w * h : plan[r].nload;
         load_and_search(n, plan[r].typed, plan[r].st, plan[r].has, plan[r].hold);
      end

      while (item_count < 290) begin
         if ($urandom_range(0, 7) == 0) begin
            w = 16;
            h = $urandom_range(1, 3);
         end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
         end
         cw = w;
         ch = h;
         if (w == 16 && $urandom_range(0, 1)) cw = $urandom_range(16, 31);
         if (h == 1 && $urandom_range(0, 1)) ch = 0;
         if ($urandom_range(0, 6) == 0) begin
            sx = $urandom_range(0, 15);
            sy = $urandom_range(0, 15);
            gx = $urandom_range(0, 15);
            gy = $urandom_range(0, 15);
         end else begin
            sx = $urandom_range(0, w - 1);
            sy = $urandom_range(0, h - 1);
            gx = $urandom_range(0, w - 1);
            gy = $urandom_range(0, h - 1);
         end
         set_grid(cw, ch, sx, sy, gx, gy);
         for (int i = 0; i < NCELLS; i++) run_walls[i] = ($urandom_range(0, 3) == 0);
         n = w * h;
         all_known = 1;
         for (int i = 0; i < w * h; i++) if (!cell_written[i]) all_known = 0;
         case ($urandom_range(0, 7))
            0: if (all_known) n = $urandom_range(1, w * h);
            1: n = w * h + $urandom_range(1, 8);
            default: ;
         endcase
         load_and_search(n, 0, ST_FOUND, 1'b0, 0);
      end

      repeat (50) @(posedge clock);
      if (fail_count == 0 && path_exp_q.size() == 0)
         $display("tb_grid_astar_path_search_unit passed");
      else
         $display("tb_grid_astar_path_search_unit failed");
      $finish;
   end

endmodule

`default_nettype wire
